// ===== rtl/fst_pkg.sv =====
package fst_pkg;

  localparam int unsigned SAMPLE_W = 10;
  localparam int unsigned POS_W    = 8;
  localparam int unsigned KEY_W    = 8;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [KEY_W-1:0] KEY_UP    = 8'h55;
  localparam logic [KEY_W-1:0] KEY_DOWN  = 8'h44;
  localparam logic [KEY_W-1:0] KEY_RIGHT = 8'h52;
  localparam logic [KEY_W-1:0] KEY_LEFT  = 8'h4C;

  localparam logic REQ_AUTO   = 1'b0;
  localparam logic REQ_MANUAL = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_VERT_LOW   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VERT_HIGH  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HORIZ_LOW  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HORIZ_HIGH = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_VERT_START = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_HORIZ_START = 3'd5;

  localparam logic [POS_W-1:0] LOW_LIMIT_RST  = 8'd0;
  localparam logic [POS_W-1:0] HIGH_LIMIT_RST = 8'd180;
  localparam logic [POS_W-1:0] START_RST      = 8'd90;

  typedef struct packed {
    logic                req_type;
    logic [SAMPLE_W-1:0] top_left;
    logic [SAMPLE_W-1:0] top_right;
    logic [SAMPLE_W-1:0] bottom_left;
    logic [SAMPLE_W-1:0] bottom_right;
    logic [SAMPLE_W-1:0] tolerance;
    logic [KEY_W-1:0]    key_code;
  } fst_in_t;

  typedef struct packed {
    logic [POS_W-1:0] vert_position;
    logic [POS_W-1:0] horiz_position;
    logic             vert_moved;
    logic             horiz_moved;
  } fst_out_t;

endpackage

// ===== rtl/fst_in_if.sv =====
interface fst_in_if import fst_pkg::*; ();
  logic    valid;
  logic    ready;
  fst_in_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/fst_out_if.sv =====
interface fst_out_if import fst_pkg::*; ();
  logic     valid;
  logic     ready;
  fst_out_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/four_sensor_sun_tracker.sv =====
// Dual-axis light tracker with four sensors.
// req: one item per sample set (req_type 0) or manual key (req_type 1).
//   An item is taken at a rising edge with req.valid and req.ready high.
// rsp: one item per request with both axis positions and move flags.
// cfg_we/cfg_index/cfg_data: write-only limit registers, written
//   at any edge with cfg_we high; write them only while the block is idle.
//   Indexes above 3 are ignored, so start writes (4 and 5) have no effect and
//   reset always restores the default start position of 90.
// Path: an item taken sits in the input register, is worked and lands in
//   the result register once that is empty or being taken; rsp.valid rises
//   as it lands.
// Throughput: one item per cycle while rsp.ready stays high; the position
//   update is a single add, compare and clamp per axis between the input and result registers.
// Stall: when rsp.ready is low the result holds, the input register takes
//   one more item only if it is empty, then req.ready drops until the result is taken.
// Reset (rst, synchronous): both stages empty, limits back to 0 and 180,
//   positions back to 90.
module four_sensor_sun_tracker import fst_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  fst_in_if.sink               req,
  fst_out_if.source            rsp,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [POS_W-1:0]     cfg_data
);

  logic [POS_W-1:0] vert_low_limit;
  logic [POS_W-1:0] vert_high_limit;
  logic [POS_W-1:0] horiz_low_limit;
  logic [POS_W-1:0] horiz_high_limit;

  logic [POS_W-1:0] vert_pos;
  logic [POS_W-1:0] horiz_pos;
  logic [POS_W-1:0] vert_pos_next;
  logic [POS_W-1:0] horiz_pos_next;

  fst_in_t  in_r;
  logic     in_valid;
  fst_out_t out_r;
  logic     out_valid;
  logic     advance;

  logic                vert_moved_next;
  logic                horiz_moved_next;
  logic [SAMPLE_W-1:0] top_mean;
  logic [SAMPLE_W-1:0] bot_mean;
  logic [SAMPLE_W-1:0] lft_mean;
  logic [SAMPLE_W-1:0] rgt_mean;
  logic [SAMPLE_W:0]   diff_v;
  logic [SAMPLE_W:0]   diff_h;
  logic [SAMPLE_W:0]   mag_v;
  logic [SAMPLE_W:0]   mag_h;
  logic                vert_up;
  logic                vert_down;
  logic                horiz_up;
  logic                horiz_down;

  assign advance   = in_valid && (!out_valid || rsp.ready);
  assign req.ready = !in_valid || advance;
  assign rsp.valid = out_valid;
  assign rsp.data  = out_r;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      vert_low_limit   <= LOW_LIMIT_RST;
      vert_high_limit  <= HIGH_LIMIT_RST;
      horiz_low_limit  <= LOW_LIMIT_RST;
      horiz_high_limit <= HIGH_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_VERT_LOW:   vert_low_limit   <= cfg_data;
        CFG_VERT_HIGH:  vert_high_limit  <= cfg_data;
        CFG_HORIZ_LOW:  horiz_low_limit  <= cfg_data;
        CFG_HORIZ_HIGH: horiz_high_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  // pair means and axis differences
  always_comb begin
    top_mean = SAMPLE_W'(({1'b0, in_r.top_left} + {1'b0, in_r.top_right}) >> 1);
    bot_mean = SAMPLE_W'(({1'b0, in_r.bottom_left} + {1'b0, in_r.bottom_right}) >> 1);
    lft_mean = SAMPLE_W'(({1'b0, in_r.top_left} + {1'b0, in_r.bottom_left}) >> 1);
    rgt_mean = SAMPLE_W'(({1'b0, in_r.top_right} + {1'b0, in_r.bottom_right}) >> 1);
    diff_v   = {1'b0, top_mean} - {1'b0, bot_mean};
    diff_h   = {1'b0, lft_mean} - {1'b0, rgt_mean};
    mag_v    = diff_v[SAMPLE_W] ? (~diff_v + 1'b1) : diff_v;
    mag_h    = diff_h[SAMPLE_W] ? (~diff_h + 1'b1) : diff_h;
  end

  // step decode
  always_comb begin
    vert_up    = 1'b0;
    vert_down  = 1'b0;
    horiz_up   = 1'b0;
    horiz_down = 1'b0;
    if (in_r.req_type == REQ_AUTO) begin
      if (mag_v > {1'b0, in_r.tolerance}) begin
        vert_up   = !diff_v[SAMPLE_W];
        vert_down = diff_v[SAMPLE_W];
      end
      if (mag_h > {1'b0, in_r.tolerance}) begin
        horiz_down = !diff_h[SAMPLE_W];
        horiz_up   = diff_h[SAMPLE_W];
      end
    end else begin
      priority case (in_r.key_code)
        KEY_UP:    vert_up    = 1'b1;
        KEY_DOWN:  vert_down  = 1'b1;
        KEY_RIGHT: horiz_up   = 1'b1;
        KEY_LEFT:  horiz_down = 1'b1;
        default: ;
      endcase
    end
    vert_moved_next  = vert_up || vert_down;
    horiz_moved_next = horiz_up || horiz_down;
  end

  // clamped steps, only the limit on the side of the step is checked
  always_comb begin
    vert_pos_next = vert_pos;
    if (vert_up) begin
      vert_pos_next = (vert_pos >= vert_high_limit) ? vert_high_limit : vert_pos + 1'b1;
    end else if (vert_down) begin
      vert_pos_next = (vert_pos <= vert_low_limit) ? vert_low_limit : vert_pos - 1'b1;
    end
    horiz_pos_next = horiz_pos;
    if (horiz_up) begin
      horiz_pos_next = (horiz_pos >= horiz_high_limit) ? horiz_high_limit
                                                       : horiz_pos + 1'b1;
    end else if (horiz_down) begin
      horiz_pos_next = (horiz_pos <= horiz_low_limit) ? horiz_low_limit
                                                      : horiz_pos - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
      vert_pos  <= START_RST;
      horiz_pos <= START_RST;
    end else begin
      if (req.ready) begin
        in_valid <= req.valid;
      end
      if (advance) begin
        out_valid <= 1'b1;
        vert_pos  <= vert_pos_next;
        horiz_pos <= horiz_pos_next;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      in_r <= req.data;
    end
    if (advance) begin
      out_r.vert_position  <= vert_pos_next;
      out_r.horiz_position <= horiz_pos_next;
      out_r.vert_moved     <= vert_moved_next;
      out_r.horiz_moved    <= horiz_moved_next;
    end
  end

`ifndef SYNTH
  a_pos_hold: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(vert_pos) && $stable(horiz_pos))
    else $error("position changed without an item");

  a_advance_out: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid && rsp.data.vert_position == vert_pos
                && rsp.data.horiz_position == horiz_pos)
    else $error("result does not match position state");

  a_unknown_key: assert property (@(posedge clk) disable iff (rst)
    advance && in_r.req_type == REQ_MANUAL && in_r.key_code != KEY_UP
    && in_r.key_code != KEY_DOWN && in_r.key_code != KEY_RIGHT
    && in_r.key_code != KEY_LEFT
    |=> !rsp.data.vert_moved && !rsp.data.horiz_moved)
    else $error("unknown key reported a move");
`endif

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import fst_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;
  localparam logic [KEY_W-1:0] KEY_LOWER_U = 8'h75;
  localparam logic [KEY_W-1:0] KEY_ZERO    = 8'h00;
  localparam logic [KEY_W-1:0] KEY_ONES    = 8'hFF;
  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 10'd1023;
  localparam int HOLD_CYCLES   = 300;
  localparam int QUIET_LIMIT   = 3000;
  localparam int SETTLE_CYCLES = 4;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [POS_W-1:0]     cfg_data;

  fst_in_if  req_if ();
  fst_out_if rsp_if ();

  four_sensor_sun_tracker dut (
    .clk(clk),
    .rst(rst),
    .req(req_if),
    .rsp(rsp_if),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  logic [POS_W-1:0] v_low, v_high, h_low, h_high, v_start, h_start;
  logic [POS_W-1:0] v_pos, h_pos;
  fst_out_t         pending_pos[$];
  int               mismatches = 0;
  int               idle_pct = 0;
  int               stall_pct = 0;
  int               hold_seq = 0;
  int               hold_seen = 0;
  int               hold_left = 0;
  int               quiet = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [POS_W-1:0] step_up_pos(logic [POS_W-1:0] pos,
                                                   logic [POS_W-1:0] high);
    logic [POS_W:0] nxt;
    nxt = {1'b0, pos} + 1'b1;
    if (nxt > {1'b0, high}) nxt = {1'b0, high};
    return nxt[POS_W-1:0];
  endfunction

  function automatic logic [POS_W-1:0] step_down_pos(logic [POS_W-1:0] pos,
                                                     logic [POS_W-1:0] low);
    int nxt;
    nxt = int'(pos) - 1;
    if (nxt < int'(low)) nxt = int'(low);
    return nxt[POS_W-1:0];
  endfunction

  // advances the tracked positions by one item and returns the result it gives
  function automatic fst_out_t track_step(fst_in_t it);
    int       top, bot, lft, rgt, dv, dh, tol;
    fst_out_t r;
    r = '0;
    if (it.req_type == REQ_AUTO) begin
      tol = int'(it.tolerance);
      top = (int'(it.top_left) + int'(it.top_right)) / 2;
      bot = (int'(it.bottom_left) + int'(it.bottom_right)) / 2;
      lft = (int'(it.top_left) + int'(it.bottom_left)) / 2;
      rgt = (int'(it.top_right) + int'(it.bottom_right)) / 2;
      dv = top - bot;
      dh = lft - rgt;
      if (dv > tol || dv < -tol) begin
        r.vert_moved = 1'b1;
        if (top > bot) v_pos = step_up_pos(v_pos, v_high);
        else if (top < bot) v_pos = step_down_pos(v_pos, v_low);
      end
      if (dh > tol || dh < -tol) begin
        r.horiz_moved = 1'b1;
        if (lft > rgt) h_pos = step_down_pos(h_pos, h_low);
        else if (lft < rgt) h_pos = step_up_pos(h_pos, h_high);
      end
    end else begin
      case (it.key_code)
        KEY_UP: begin
          r.vert_moved = 1'b1;
          v_pos = step_up_pos(v_pos, v_high);
        end
        KEY_DOWN: begin
          r.vert_moved = 1'b1;
          v_pos = step_down_pos(v_pos, v_low);
        end
        KEY_RIGHT: begin
          r.horiz_moved = 1'b1;
          h_pos = step_up_pos(h_pos, h_high);
        end
        KEY_LEFT: begin
          r.horiz_moved = 1'b1;
          h_pos = step_down_pos(h_pos, h_low);
        end
        default: ;
      endcase
    end
    r.vert_position  = v_pos;
    r.horiz_position = h_pos;
    return r;
  endfunction

  always @(posedge clk) begin
    fst_out_t want;
    if (rst) begin
      v_low   = LOW_LIMIT_RST;
      v_high  = HIGH_LIMIT_RST;
      h_low   = LOW_LIMIT_RST;
      h_high  = HIGH_LIMIT_RST;
      v_start = START_RST;
      h_start = START_RST;
      v_pos   = START_RST;
      h_pos   = START_RST;
      pending_pos.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_VERT_LOW:    v_low = cfg_data;
          CFG_VERT_HIGH:   v_high = cfg_data;
          CFG_HORIZ_LOW:   h_low = cfg_data;
          CFG_HORIZ_HIGH:  h_high = cfg_data;
          CFG_VERT_START:  v_start = cfg_data;
          CFG_HORIZ_START: h_start = cfg_data;
          default: ;
        endcase
      end
      if (rsp_if.valid && rsp_if.ready) begin
        if (pending_pos.size() == 0) begin
          $error("result item with no expectation waiting");
          mismatches++;
        end else begin
          want = pending_pos.pop_front();
          if (rsp_if.data.vert_position !== want.vert_position) begin
            $error("vert_position expected %0d actual %0d",
                   want.vert_position, rsp_if.data.vert_position);
            mismatches++;
          end
          if (rsp_if.data.horiz_position !== want.horiz_position) begin
            $error("horiz_position expected %0d actual %0d",
                   want.horiz_position, rsp_if.data.horiz_position);
            mismatches++;
          end
          if (rsp_if.data.vert_moved !== want.vert_moved) begin
            $error("vert_moved expected %0d actual %0d",
                   want.vert_moved, rsp_if.data.vert_moved);
            mismatches++;
          end
          if (rsp_if.data.horiz_moved !== want.horiz_moved) begin
            $error("horiz_moved expected %0d actual %0d",
                   want.horiz_moved, rsp_if.data.horiz_moved);
            mismatches++;
          end
        end
      end
      if (req_if.valid && req_if.ready) pending_pos.push_back(track_step(req_if.data));
    end
  end

  // result side: random stalls, or a long hold-off when one is requested
  always @(posedge clk) begin
    if (hold_seq != hold_seen) begin
      hold_seen <= hold_seq;
      hold_left <= HOLD_CYCLES;
      rsp_if.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("four_sensor_sun_tracker regression: fail");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic send_item(input fst_in_t it);
    while ($urandom_range(99) < idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.data  <= it;
    @(posedge clk);
    while (req_if.ready !== 1'b1) @(posedge clk);
  endtask

  task automatic wait_idle();
    req_if.valid <= 1'b0;
    @(posedge clk);
    while (pending_pos.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [POS_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  task automatic set_limits(input logic [POS_W-1:0] vl, input logic [POS_W-1:0] vh,
                            input logic [POS_W-1:0] hl, input logic [POS_W-1:0] hh);
    wait_idle();
    write_reg(CFG_VERT_LOW, vl);
    write_reg(CFG_VERT_HIGH, vh);
    write_reg(CFG_HORIZ_LOW, hl);
    write_reg(CFG_HORIZ_HIGH, hh);
    write_reg(CFG_VERT_START, POS_W'($urandom_range(180)));
    write_reg(CFG_HORIZ_START, POS_W'($urandom_range(180)));
    write_reg(CFG_SPARE, POS_W'($urandom_range(255)));
    cfg_we <= 1'b0;
  endtask

  function automatic fst_in_t auto_item(logic [SAMPLE_W-1:0] tl, logic [SAMPLE_W-1:0] tr,
                                        logic [SAMPLE_W-1:0] bl, logic [SAMPLE_W-1:0] br,
                                        logic [SAMPLE_W-1:0] tol);
    fst_in_t it;
    it.req_type     = REQ_AUTO;
    it.top_left     = tl;
    it.top_right    = tr;
    it.bottom_left  = bl;
    it.bottom_right = br;
    it.tolerance    = tol;
    it.key_code     = KEY_W'($urandom_range(255));
    return it;
  endfunction

  function automatic fst_in_t manual_item(logic [KEY_W-1:0] key);
    fst_in_t it;
    it = auto_item(SAMPLE_W'($urandom_range(1023)), SAMPLE_W'($urandom_range(1023)),
                   SAMPLE_W'($urandom_range(1023)), SAMPLE_W'($urandom_range(1023)),
                   SAMPLE_W'($urandom_range(1023)));
    it.req_type = REQ_MANUAL;
    it.key_code = key;
    return it;
  endfunction

  function automatic fst_in_t random_item();
    fst_in_t          it;
    logic [KEY_W-1:0] key;
    logic [SAMPLE_W-1:0] tol;
    case ($urandom_range(3))
      0: key = KEY_UP;
      1: key = KEY_DOWN;
      2: key = KEY_RIGHT;
      default: key = KEY_LEFT;
    endcase
    if ($urandom_range(4) == 0) key = KEY_W'($urandom_range(255));
    it = manual_item(key);
    if ($urandom_range(9) < 6) begin
      case ($urandom_range(3))
        0: tol = SAMPLE_W'($urandom_range(7));
        1: tol = SAMPLE_W'($urandom_range(63));
        2: tol = SAMPLE_W'($urandom_range(255));
        default: tol = SAMPLE_W'($urandom_range(1023));
      endcase
      it.req_type  = REQ_AUTO;
      it.tolerance = tol;
    end
    return it;
  endfunction

  task automatic test_sample_extremes();
    send_item(auto_item(0, 0, 0, 0, 0));
    send_item(auto_item(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, 0));
    send_item(auto_item(SAMPLE_MAX, SAMPLE_MAX, 0, 0, SAMPLE_MAX));
    send_item(auto_item(SAMPLE_MAX, SAMPLE_MAX, 0, 0, SAMPLE_MAX - 1'b1));
    send_item(auto_item(0, 0, SAMPLE_MAX, SAMPLE_MAX, 0));
    send_item(auto_item(SAMPLE_MAX, 0, SAMPLE_MAX, 0, 0));
    send_item(auto_item(0, SAMPLE_MAX, 0, SAMPLE_MAX, 0));
    // difference right at the dead band edge, then one past it
    send_item(auto_item(11, 11, 1, 1, 10));
    send_item(auto_item(11, 11, 1, 1, 9));
    // odd pair sums round down to no difference
    send_item(auto_item(1, 0, 0, 0, 0));
  endtask

  task automatic test_manual_keys();
    send_item(manual_item(KEY_UP));
    send_item(manual_item(KEY_DOWN));
    send_item(manual_item(KEY_RIGHT));
    send_item(manual_item(KEY_LEFT));
    send_item(manual_item(KEY_ZERO));
    send_item(manual_item(KEY_ONES));
    send_item(manual_item(KEY_LOWER_U));
  endtask

  task automatic test_limit_clamp();
    // narrow vertical range, crossed horizontal limits
    set_limits(89, 91, 120, 60);
    repeat (3) send_item(manual_item(KEY_UP));
    repeat (3) send_item(manual_item(KEY_DOWN));
    send_item(manual_item(KEY_RIGHT));
    send_item(manual_item(KEY_LEFT));
  endtask

  task automatic test_random_tracking(input int idle, input int stall, input int count,
                                      input logic [POS_W-1:0] vl, input logic [POS_W-1:0] vh,
                                      input logic [POS_W-1:0] hl, input logic [POS_W-1:0] hh);
    set_limits(vl, vh, hl, hh);
    idle_pct  = idle;
    stall_pct = stall;
    repeat (count) send_item(random_item());
  endtask

  task automatic test_output_hold();
    wait_idle();
    idle_pct  = 0;
    stall_pct = 0;
    hold_seq <= hold_seq + 1;
    repeat (40) send_item(random_item());
  endtask

  task automatic test_sender_pause();
    idle_pct  = 11;
    stall_pct = 11;
    repeat (20) send_item(random_item());
    wait_idle();
    repeat (20) send_item(random_item());
  endtask

  initial begin
    rst          = 1'b1;
    cfg_we       = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    req_if.valid = 1'b0;
    req_if.data  = '0;
    rsp_if.ready = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    test_sample_extremes();
    test_manual_keys();
    test_limit_clamp();
    test_random_tracking(0, 0, 230, 0, 180, 0, 180);
    test_random_tracking(78, 0, 230, 80, 100, 85, 95);
    test_random_tracking(0, 78, 230, 150, 30, 180, 0);
    test_random_tracking(11, 11, 230, POS_W'($urandom_range(180)),
                         POS_W'($urandom_range(180)), POS_W'($urandom_range(180)),
                         POS_W'($urandom_range(180)));
    test_output_hold();
    test_sender_pause();
    wait_idle();

    if (pending_pos.size() != 0) begin
      $error("%0d expected result items never arrived", pending_pos.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("four_sensor_sun_tracker regression: pass");
    end else begin
      $display("four_sensor_sun_tracker regression: fail");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/fst_pkg.sv
rtl/fst_in_if.sv
rtl/fst_out_if.sv
rtl/four_sensor_sun_tracker.sv
tb/testbench.sv
